// ===== hw/rtl/rhc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_pkg: shared types and constants of the RGB to HSV converter
// Channel, field and divider widths, sector codes, the item structs and one
// step of the restoring divider.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int HUE_FRAC_BITS = 6;
  localparam int SAT_FRAC_BITS = 12;

  localparam int CHAN_W = 8;
  localparam int HUE_W  = 15;
  localparam int SAT_W  = 13;

  // One 60 degree sector and the full circle in hue units
  localparam int SECTOR_UNITS = 60 << HUE_FRAC_BITS;
  localparam int CIRCLE_UNITS = 360 << HUE_FRAC_BITS;
  localparam int SECT_W       = $clog2(SECTOR_UNITS + 1);
  localparam int CIRC_W       = $clog2(CIRCLE_UNITS + 1);
  localparam int HUE_CALC_W   = (CIRC_W > HUE_W) ? CIRC_W : HUE_W;

  // Dividend widths; both dividers share one pipeline of DIV_W steps
  localparam int HUE_DVD_W = CHAN_W + SECT_W;
  localparam int SAT_DVD_W = CHAN_W + SAT_FRAC_BITS;
  localparam int DIV_W     = (HUE_DVD_W > SAT_DVD_W) ? HUE_DVD_W : SAT_DVD_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Sector of the largest channel
  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;

  typedef logic [CHAN_W-1:0]     chan_t;
  typedef logic [DIV_W-1:0]      dvd_t;
  typedef logic [HUE_DVD_W-1:0]  hue_dvd_t;
  typedef logic [HUE_CALC_W-1:0] hue_calc_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [HUE_W-1:0]  hue_angle;
    logic [SAT_W-1:0]  saturation;
    logic [CHAN_W-1:0] brightness;
  } hsv_out_t;

  // Classification that travels alongside the division
  typedef struct packed {
    logic [1:0]        sector;
    logic              neg;
    logic              gray;
    logic              black;
    logic [CHAN_W-1:0] delta;
    logic [CHAN_W-1:0] brightness;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [DIV_W-1:0]  hue_dvd;
    logic [DIV_W-1:0]  sat_dvd;
  } q_item_t;

  // Restoring divider state: partial remainder and dividend/quotient shifter
  typedef struct packed {
    logic [CHAN_W-1:0] rem;
    logic [DIV_W-1:0]  quo;
  } div_st_t;

  function automatic div_st_t div_step(input div_st_t cur, input logic [CHAN_W-1:0] dvs);
    logic [CHAN_W:0] shifted;
    logic [CHAN_W:0] diff;
    div_st_t         nxt;
    shifted = {cur.rem, cur.quo[DIV_W-1]};
    diff    = shifted - {1'b0, dvs};
    if (!diff[CHAN_W]) begin
      nxt.rem = diff[CHAN_W-1:0];
      nxt.quo = {cur.quo[DIV_W-2:0], 1'b1};
    end else begin
      nxt.rem = shifted[CHAN_W-1:0];
      nxt.quo = {cur.quo[DIV_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

// ===== hw/rtl/rhc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_front: input stage of the RGB to HSV converter
// Accepts pixels, finds max, min and sector, and forms both dividends.
// ----------------------------------------------------------------------------
module rhc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rhc_pkg::pix_in_t in_data,
  input  logic             q_full,
  output logic             push,
  output rhc_pkg::q_item_t push_item
);

  logic             vld_r;
  logic             vld_nxt;
  rhc_pkg::q_item_t item_r;
  rhc_pkg::q_item_t item_nxt;
  logic             take;

  rhc_pkg::chan_t   mx;
  rhc_pkg::chan_t   mn;
  logic [1:0]       sector;
  rhc_pkg::chan_t   num_a;
  rhc_pkg::chan_t   num_b;
  logic [rhc_pkg::CHAN_W:0] num_diff;
  rhc_pkg::chan_t   num_abs;
  rhc_pkg::chan_t   delta;

  assign push     = vld_r && !q_full;
  assign in_stall = vld_r && q_full;
  assign take     = in_valid && !in_stall;

  always_comb begin
    mx = in_data.red;
    mn = in_data.red;
    if (in_data.green > mx) mx = in_data.green;
    if (in_data.blue > mx) mx = in_data.blue;
    if (in_data.green < mn) mn = in_data.green;
    if (in_data.blue < mn) mn = in_data.blue;
    delta = mx - mn;

    // Ties go to red, then green
    if (in_data.red >= in_data.green && in_data.red >= in_data.blue) begin
      sector = rhc_pkg::SEC_RED;
      num_a  = in_data.green;
      num_b  = in_data.blue;
    end else if (in_data.green >= in_data.blue) begin
      sector = rhc_pkg::SEC_GREEN;
      num_a  = in_data.blue;
      num_b  = in_data.red;
    end else begin
      sector = rhc_pkg::SEC_BLUE;
      num_a  = in_data.red;
      num_b  = in_data.green;
    end

    num_diff = {1'b0, num_a} - {1'b0, num_b};
    num_abs  = num_diff[rhc_pkg::CHAN_W] ? (num_b - num_a) : num_diff[rhc_pkg::CHAN_W-1:0];

    item_nxt.side.sector     = sector;
    item_nxt.side.neg        = num_diff[rhc_pkg::CHAN_W];
    item_nxt.side.gray       = (delta == '0);
    item_nxt.side.black      = (mx == '0);
    item_nxt.side.delta      = delta;
    item_nxt.side.brightness = mx;
    item_nxt.hue_dvd = rhc_pkg::dvd_t'(rhc_pkg::hue_dvd_t'(rhc_pkg::SECTOR_UNITS)
                                       * rhc_pkg::hue_dvd_t'(num_abs));
    item_nxt.sat_dvd = rhc_pkg::dvd_t'(delta) << rhc_pkg::SAT_FRAC_BITS;
  end

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

  assign push_item = item_r;

endmodule

// ===== hw/rtl/rhc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_queue: short queue between front and back
// Register FIFO; pointers wrap on their own as the depth is a power of two.
// ----------------------------------------------------------------------------
module rhc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rhc_pkg::q_item_t push_item,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output rhc_pkg::q_item_t head
);

  rhc_pkg::q_item_t            entry_r [rhc_pkg::QUEUE_DEPTH];
  logic [rhc_pkg::QPTR_W-1:0]  wr_ptr_r;
  logic [rhc_pkg::QPTR_W-1:0]  wr_ptr_nxt;
  logic [rhc_pkg::QPTR_W-1:0]  rd_ptr_r;
  logic [rhc_pkg::QPTR_W-1:0]  rd_ptr_nxt;
  logic [rhc_pkg::QCNT_W-1:0]  cnt_r;
  logic [rhc_pkg::QCNT_W-1:0]  cnt_nxt;

  assign full  = (cnt_r == rhc_pkg::QCNT_W'(rhc_pkg::QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/rhc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_back: division pipeline and output register
// Two restoring dividers, one quotient bit per stage, then hue assembly.
// ----------------------------------------------------------------------------
module rhc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  rhc_pkg::q_item_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output rhc_pkg::hsv_out_t out_data
);

  localparam int NSTG = rhc_pkg::DIV_W;
  localparam int LAST = NSTG - 1;

  logic              adv;
  logic              vld_r   [NSTG];
  logic              vld_nxt [NSTG];
  rhc_pkg::div_st_t  hdiv_r  [NSTG];
  rhc_pkg::div_st_t  hdiv_nxt[NSTG];
  rhc_pkg::div_st_t  sdiv_r  [NSTG];
  rhc_pkg::div_st_t  sdiv_nxt[NSTG];
  rhc_pkg::side_t    side_r  [NSTG];
  rhc_pkg::side_t    side_nxt[NSTG];

  logic              out_vld_r;
  rhc_pkg::hsv_out_t out_data_r;
  rhc_pkg::hsv_out_t out_data_nxt;

  rhc_pkg::div_st_t  hdiv_in;
  rhc_pkg::div_st_t  sdiv_in;
  rhc_pkg::hue_calc_t q_h;
  rhc_pkg::hue_calc_t hue_base;
  rhc_pkg::hue_calc_t hue_full;
  logic              rem_nz;

  // Whole pipeline moves together; it freezes only while a result waits
  assign adv = !out_vld_r || !out_stall;
  assign pop = adv && !q_empty;

  assign hdiv_in.rem = '0;
  assign hdiv_in.quo = head.hue_dvd;
  assign sdiv_in.rem = '0;
  assign sdiv_in.quo = head.sat_dvd;

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    if (s == 0) begin : g_first
      always_comb begin
        vld_nxt[s]  = pop;
        side_nxt[s] = head.side;
        hdiv_nxt[s] = rhc_pkg::div_step(hdiv_in, head.side.delta);
        sdiv_nxt[s] = rhc_pkg::div_step(sdiv_in, head.side.brightness);
      end
    end else begin : g_rest
      always_comb begin
        vld_nxt[s]  = vld_r[s-1];
        side_nxt[s] = side_r[s-1];
        hdiv_nxt[s] = rhc_pkg::div_step(hdiv_r[s-1], side_r[s-1].delta);
        sdiv_nxt[s] = rhc_pkg::div_step(sdiv_r[s-1], side_r[s-1].brightness);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (adv) begin
        vld_r[s] <= vld_nxt[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[s] <= side_nxt[s];
        hdiv_r[s] <= hdiv_nxt[s];
        sdiv_r[s] <= sdiv_nxt[s];
      end
    end
  end

  // Hue: base plus or minus the sector fraction, truncated toward zero
  always_comb begin
    q_h    = hdiv_r[LAST].quo[rhc_pkg::HUE_CALC_W-1:0];
    rem_nz = (hdiv_r[LAST].rem != '0);
    case (side_r[LAST].sector)
      rhc_pkg::SEC_GREEN: hue_base = rhc_pkg::hue_calc_t'(2 * rhc_pkg::SECTOR_UNITS);
      rhc_pkg::SEC_BLUE:  hue_base = rhc_pkg::hue_calc_t'(4 * rhc_pkg::SECTOR_UNITS);
      default:            hue_base = '0;
    endcase

    if (side_r[LAST].gray) begin
      hue_full = '0;
    end else if (!side_r[LAST].neg) begin
      hue_full = hue_base + q_h;
    end else if (side_r[LAST].sector == rhc_pkg::SEC_RED) begin
      // Negative red hue wraps round the circle unless it truncated to zero
      hue_full = (q_h == '0) ? '0
               : rhc_pkg::hue_calc_t'(rhc_pkg::CIRCLE_UNITS) - q_h;
    end else begin
      hue_full = hue_base - q_h - rhc_pkg::hue_calc_t'(rem_nz);
    end

    out_data_nxt.hue_angle  = hue_full[rhc_pkg::HUE_W-1:0];
    out_data_nxt.saturation = side_r[LAST].black ? '0
                            : sdiv_r[LAST].quo[rhc_pkg::SAT_W-1:0];
    out_data_nxt.brightness = side_r[LAST].brightness;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= vld_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/rgb_to_hsv_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter: 8-bit RGB pixel to fixed-point HSV
// Front stage, two-entry queue and a pipelined division back end.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_data carries one RGB pixel per item.
//   Output channel out_valid / out_stall / out_data carries one HSV item for
//   each pixel, in order: hue in 1/64 degree, saturation with 4096 as 1.0,
//   brightness as the largest channel.
//   Throughput: one item per clock, sustained, with no gap between items, while out_stall stays low.
//   Path: the front register loads at the edge that accepts a pixel, then
//   one queue slot, DIV_W divider stages (one quotient bit each for hue and
//   saturation) and the output register follow, and out_valid then rises.
//   The divider depth is set by the dividend width.
//   Stalls: the divider pipeline and output register hold while out_stall is
//   high with a result showing; the front keeps accepting until the queue
//   and front register fill, then raises in_stall.
//   Reset (rst_n low, synchronous) empties every stage and the queue; no
//   clearing pass is needed and items are taken in the next cycle.
//   There is no configuration and no state carried from one pixel to the next.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rhc_pkg::pix_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rhc_pkg::hsv_out_t out_data
);

  // Front to queue
  logic             push;
  rhc_pkg::q_item_t push_item;
  logic             q_full;
  // Queue to back
  logic             pop;
  logic             q_empty;
  rhc_pkg::q_item_t head;

  // Classify the pixel and form the dividends
  rhc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // Decouple the front from stalls at the output
  rhc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  // Divide, assemble hue and hold the result for the receiver
  rhc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/rhc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhc_checker: port checks for the RGB to HSV converter
// Handshakes on both channels and relations between the HSV fields.
// ----------------------------------------------------------------------------
module rhc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input rhc_pkg::pix_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input rhc_pkg::hsv_out_t out_data
);

  // A stalled input item stays offered and unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input item changed while stalled");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // Black pixel gives zero saturation and zero hue
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.brightness == '0 |->
      out_data.saturation == '0 && out_data.hue_angle == '0)
    else $error("black pixel with non-zero hue or saturation");

  // A non-zero hue needs a non-zero spread, hence non-zero saturation
  a_hue_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hue_angle != '0 |-> out_data.saturation != '0)
    else $error("hue set on a gray pixel");

endmodule

bind rgb_to_hsv_converter rhc_checker u_rhc_checker (.*);
